// File: hw/rtl/pbr_pkg.sv
// Shared types, constants and the control program of the polynomial bisection root finder.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`timescale 1ns / 1ps

package pbr_pkg;

    // Number format and limits
    localparam int XW          = 32;              // Q16.16 value width
    localparam int FRAC_BITS   = 16;
    localparam int MAX_DEGREE  = 6;
    localparam int NUM_COEF    = MAX_DEGREE + 1;
    localparam int DEG_W       = 3;
    localparam int COEF_IDX_W  = $clog2(NUM_COEF);
    localparam int MAX_STEPS   = 48;
    localparam int CNT_W       = 6;               // step counters
    localparam int TOL_W       = 31;
    localparam int KSHIFT_LIMIT = 33;             // tol << k is compared only for k below this
    localparam int TSH_W       = 64;              // holds tol << 32
    localparam int PROD_W      = 2 * XW;

    // Configuration register indexes
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF0  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = CFG_IDX_W'(NUM_COEF);

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_NOSIGN = 2'd2;

    // Payload of one input transfer
    typedef struct packed {
        logic signed [XW-1:0]    left_end;
        logic signed [XW-1:0]    right_end;
        logic        [TOL_W-1:0] tolerance;
    } t_in_item;

    // Payload of one result transfer
    typedef struct packed {
        logic signed [XW-1:0]    root_estimate;
        logic signed [XW-1:0]    value_at_root;
        logic        [CNT_W-1:0] steps_done;
        logic        [CNT_W-1:0] step_limit;
        logic        [1:0]       status;
    } t_out_item;

    // Configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Horner unit request and response
    typedef struct packed {
        logic                 start;
        logic signed [XW-1:0] x;
    } t_eval_req;

    typedef struct packed {
        logic                 busy;
        logic signed [XW-1:0] result;
    } t_eval_rsp;

    // Micro-operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
    localparam logic [OP_W-1:0] OP_EVAL_A     = 4'd2;
    localparam logic [OP_W-1:0] OP_EVAL_B     = 4'd3;
    localparam logic [OP_W-1:0] OP_STORE_FA   = 4'd4;
    localparam logic [OP_W-1:0] OP_STORE_FB   = 4'd5;
    localparam logic [OP_W-1:0] OP_KINIT      = 4'd6;
    localparam logic [OP_W-1:0] OP_KSTEP      = 4'd7;
    localparam logic [OP_W-1:0] OP_MID        = 4'd8;
    localparam logic [OP_W-1:0] OP_STORE_FM   = 4'd9;
    localparam logic [OP_W-1:0] OP_UPDATE     = 4'd10;
    localparam logic [OP_W-1:0] OP_SET_LIMIT  = 4'd11;
    localparam logic [OP_W-1:0] OP_SET_OK     = 4'd12;
    localparam logic [OP_W-1:0] OP_SET_NOSIGN = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT       = 4'd14;

    // Jump conditions
    localparam int JC_W = 4;
    localparam logic [JC_W-1:0] J_NEVER       = 4'd0;
    localparam logic [JC_W-1:0] J_ALWAYS      = 4'd1;
    localparam logic [JC_W-1:0] J_NO_INPUT    = 4'd2;
    localparam logic [JC_W-1:0] J_EVAL_BUSY   = 4'd3;
    localparam logic [JC_W-1:0] J_SAME_AB     = 4'd4;
    localparam logic [JC_W-1:0] J_KGROW       = 4'd5;
    localparam logic [JC_W-1:0] J_WITHIN_TOL  = 4'd6;
    localparam logic [JC_W-1:0] J_MORE_STEPS  = 4'd7;
    localparam logic [JC_W-1:0] J_OUT_FREE    = 4'd8;

    // Program addresses
    localparam int UPC_W     = 5;
    localparam int UCODE_LEN = 20;
    localparam logic [UPC_W-1:0] A_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] A_EVAL_A    = 5'd1;
    localparam logic [UPC_W-1:0] A_WAIT_A    = 5'd2;
    localparam logic [UPC_W-1:0] A_STORE_A   = 5'd3;
    localparam logic [UPC_W-1:0] A_EVAL_B    = 5'd4;
    localparam logic [UPC_W-1:0] A_WAIT_B    = 5'd5;
    localparam logic [UPC_W-1:0] A_STORE_B   = 5'd6;
    localparam logic [UPC_W-1:0] A_SIGN_TEST = 5'd7;
    localparam logic [UPC_W-1:0] A_KINIT     = 5'd8;
    localparam logic [UPC_W-1:0] A_KLOOP     = 5'd9;
    localparam logic [UPC_W-1:0] A_MID       = 5'd10;
    localparam logic [UPC_W-1:0] A_WAIT_M    = 5'd11;
    localparam logic [UPC_W-1:0] A_STORE_M   = 5'd12;
    localparam logic [UPC_W-1:0] A_TOL_TEST  = 5'd13;
    localparam logic [UPC_W-1:0] A_UPDATE    = 5'd14;
    localparam logic [UPC_W-1:0] A_LIMIT     = 5'd15;
    localparam logic [UPC_W-1:0] A_OK        = 5'd16;
    localparam logic [UPC_W-1:0] A_NOSIGN    = 5'd17;
    localparam logic [UPC_W-1:0] A_EMIT      = 5'd18;
    localparam logic [UPC_W-1:0] A_EMIT_HOLD = 5'd19;

    // One control word: operation, jump condition, jump target
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [JC_W-1:0]  cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    // Status flags that steer jumps
    typedef struct packed {
        logic in_valid;
        logic eval_busy;
        logic same_ab;
        logic kgrow;
        logic within_tol;
        logic more_steps;
        logic out_free;
    } t_cond;

    // Control from sequencer to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idle;
    } t_ctrl;

    // Control program; a jump falls through to the next word when its condition is false
    function automatic t_uword ucode(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NOP, cond: J_ALWAYS, target: A_IDLE};
        unique case (addr)
            A_IDLE:      w = '{op: OP_ACCEPT,     cond: J_NO_INPUT,   target: A_IDLE};
            A_EVAL_A:    w = '{op: OP_EVAL_A,     cond: J_NEVER,      target: A_IDLE};
            A_WAIT_A:    w = '{op: OP_NOP,        cond: J_EVAL_BUSY,  target: A_WAIT_A};
            A_STORE_A:   w = '{op: OP_STORE_FA,   cond: J_NEVER,      target: A_IDLE};
            A_EVAL_B:    w = '{op: OP_EVAL_B,     cond: J_NEVER,      target: A_IDLE};
            A_WAIT_B:    w = '{op: OP_NOP,        cond: J_EVAL_BUSY,  target: A_WAIT_B};
            A_STORE_B:   w = '{op: OP_STORE_FB,   cond: J_NEVER,      target: A_IDLE};
            A_SIGN_TEST: w = '{op: OP_NOP,        cond: J_SAME_AB,    target: A_NOSIGN};
            A_KINIT:     w = '{op: OP_KINIT,      cond: J_NEVER,      target: A_IDLE};
            A_KLOOP:     w = '{op: OP_KSTEP,      cond: J_KGROW,      target: A_KLOOP};
            A_MID:       w = '{op: OP_MID,        cond: J_NEVER,      target: A_IDLE};
            A_WAIT_M:    w = '{op: OP_NOP,        cond: J_EVAL_BUSY,  target: A_WAIT_M};
            A_STORE_M:   w = '{op: OP_STORE_FM,   cond: J_NEVER,      target: A_IDLE};
            A_TOL_TEST:  w = '{op: OP_NOP,        cond: J_WITHIN_TOL, target: A_OK};
            A_UPDATE:    w = '{op: OP_UPDATE,     cond: J_MORE_STEPS, target: A_MID};
            A_LIMIT:     w = '{op: OP_SET_LIMIT,  cond: J_ALWAYS,     target: A_EMIT};
            A_OK:        w = '{op: OP_SET_OK,     cond: J_ALWAYS,     target: A_EMIT};
            A_NOSIGN:    w = '{op: OP_SET_NOSIGN, cond: J_NEVER,      target: A_IDLE};
            A_EMIT:      w = '{op: OP_EMIT,       cond: J_OUT_FREE,   target: A_IDLE};
            A_EMIT_HOLD: w = '{op: OP_NOP,        cond: J_ALWAYS,     target: A_EMIT};
            default:     w = '{op: OP_NOP,        cond: J_ALWAYS,     target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/pbr_horner.sv
// Horner evaluation unit with the coefficient and degree registers.
// Depends on pbr_pkg; one multiply and one saturating add per coefficient below the top one.
`timescale 1ns / 1ps

module pbr_horner (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pbr_pkg::t_cfg_wr i_cfg,
    input  pbr_pkg::t_eval_req i_req,
    output pbr_pkg::t_eval_rsp o_rsp
);

    logic [pbr_pkg::DEG_W-1:0]             r_deg;
    logic signed [pbr_pkg::XW-1:0]         r_coef [pbr_pkg::NUM_COEF];
    logic [pbr_pkg::DEG_W-1:0]             r_cnt;
    logic                                  r_busy;
    logic                                  r_add_phase;
    logic signed [pbr_pkg::XW-1:0]         r_x;
    logic signed [pbr_pkg::XW-1:0]         r_acc;
    logic signed [pbr_pkg::PROD_W-1:0]     r_prod;

    logic [pbr_pkg::DEG_W-1:0]             eff_deg;
    logic [pbr_pkg::DEG_W-1:0]             rd_idx;
    logic signed [pbr_pkg::XW-1:0]         coef_rd;
    logic signed [pbr_pkg::PROD_W-1:0]     prod_sh;
    logic signed [pbr_pkg::XW-1:0]         prod_sat;
    logic signed [pbr_pkg::XW:0]           sum;
    logic signed [pbr_pkg::XW-1:0]         sum_sat;
    logic [pbr_pkg::COEF_IDX_W-1:0]        wr_idx;

    // Clamp degree to the top coefficient held
    assign eff_deg = (r_deg > pbr_pkg::DEG_W'(pbr_pkg::MAX_DEGREE))
                   ? pbr_pkg::DEG_W'(pbr_pkg::MAX_DEGREE) : r_deg;

    // Single coefficient read: top term on start, next lower term while adding
    assign rd_idx  = i_req.start ? eff_deg : r_cnt - pbr_pkg::DEG_W'(1);
    assign coef_rd = r_coef[rd_idx[pbr_pkg::COEF_IDX_W-1:0]];

    // Floor shift of the product, then saturate to 32 bits
    always_comb begin
        prod_sh = r_prod >>> pbr_pkg::FRAC_BITS;
        if (prod_sh > pbr_pkg::PROD_W'(signed'({1'b0, {(pbr_pkg::XW-1){1'b1}}}))) begin
            prod_sat = {1'b0, {(pbr_pkg::XW-1){1'b1}}};
        end else if (prod_sh < -(pbr_pkg::PROD_W'(signed'({1'b0, 1'b1,
                                  {(pbr_pkg::XW-1){1'b0}}})))) begin
            prod_sat = {1'b1, {(pbr_pkg::XW-1){1'b0}}};
        end else begin
            prod_sat = prod_sh[pbr_pkg::XW-1:0];
        end
        sum = {prod_sat[pbr_pkg::XW-1], prod_sat} + {coef_rd[pbr_pkg::XW-1], coef_rd};
        if (sum[pbr_pkg::XW] != sum[pbr_pkg::XW-1]) begin
            sum_sat = {sum[pbr_pkg::XW], {(pbr_pkg::XW-1){~sum[pbr_pkg::XW]}}};
        end else begin
            sum_sat = sum[pbr_pkg::XW-1:0];
        end
    end

    assign wr_idx = pbr_pkg::COEF_IDX_W'(i_cfg.idx - pbr_pkg::CFG_COEF0);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= '0;
            for (int i = 0; i < pbr_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg.we) begin
            if (i_cfg.idx == pbr_pkg::CFG_DEGREE) begin
                r_deg <= i_cfg.data[pbr_pkg::DEG_W-1:0];
            end else if (i_cfg.idx >= pbr_pkg::CFG_COEF0 &&
                         i_cfg.idx <= pbr_pkg::CFG_COEF_LAST) begin
                r_coef[wr_idx] <= i_cfg.data[pbr_pkg::XW-1:0];
            end
        end
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_add_phase <= 1'b0;
            r_cnt       <= '0;
        end else if (i_req.start) begin
            r_busy      <= (eff_deg != '0);
            r_add_phase <= 1'b0;
            r_cnt       <= eff_deg;
        end else if (r_busy) begin
            r_add_phase <= ~r_add_phase;
            if (r_add_phase) begin
                r_cnt  <= r_cnt - pbr_pkg::DEG_W'(1);
                r_busy <= (r_cnt != pbr_pkg::DEG_W'(1));
            end
        end
    end

    // Accumulator, operand and product
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= coef_rd;
            r_x   <= i_req.x;
        end else if (r_busy) begin
            if (r_add_phase) begin
                r_acc <= sum_sat;
            end else begin
                r_prod <= r_acc * r_x;
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.result = r_acc;

`ifndef SYNTHESIS
    // A constant polynomial finishes on the start cycle
    a_const_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && eff_deg == '0) |=> !r_busy)
        else $error("horner busy after start with degree zero");
    // The term counter stays nonzero for as long as the unit works
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("horner busy with empty term counter");
`endif

endmodule

// File: hw/rtl/pbr_sequencer.sv
// Microprogram sequencer: program counter over the control program in pbr_pkg.
// Depends on pbr_pkg; takes status flags from the datapath and issues one operation a cycle.
`timescale 1ns / 1ps

module pbr_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbr_pkg::t_cond i_cond,
    output pbr_pkg::t_ctrl o_ctrl
);

    logic [pbr_pkg::UPC_W-1:0] r_upc;
    logic [pbr_pkg::UPC_W-1:0] n_upc;
    pbr_pkg::t_uword           word;
    logic                      take;

    assign word = pbr_pkg::ucode(r_upc);

    // Evaluate the jump condition of the current word
    always_comb begin
        take = 1'b0;
        unique case (word.cond)
            pbr_pkg::J_NEVER:      take = 1'b0;
            pbr_pkg::J_ALWAYS:     take = 1'b1;
            pbr_pkg::J_NO_INPUT:   take = !i_cond.in_valid;
            pbr_pkg::J_EVAL_BUSY:  take = i_cond.eval_busy;
            pbr_pkg::J_SAME_AB:    take = i_cond.same_ab;
            pbr_pkg::J_KGROW:      take = i_cond.kgrow;
            pbr_pkg::J_WITHIN_TOL: take = i_cond.within_tol;
            pbr_pkg::J_MORE_STEPS: take = i_cond.more_steps;
            pbr_pkg::J_OUT_FREE:   take = i_cond.out_free;
            default:               take = 1'b1;
        endcase
        n_upc = take ? word.target : r_upc + pbr_pkg::UPC_W'(1);
    end

    // Advance the program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= pbr_pkg::A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.op   = word.op;
    assign o_ctrl.idle = (r_upc == pbr_pkg::A_IDLE);

`ifndef SYNTHESIS
    // The counter never leaves the program
    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc < pbr_pkg::UPC_W'(pbr_pkg::UCODE_LEN))
        else $error("sequencer outside program");
    // Without an input the sequencer waits at the idle word
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == pbr_pkg::A_IDLE && !i_cond.in_valid) |=> r_upc == pbr_pkg::A_IDLE)
        else $error("sequencer left idle without input");
`endif

endmodule

// File: hw/rtl/pbr_datapath.sv
// Bisection datapath: interval ends, function values, step limit, counters and result register.
// Depends on pbr_pkg; executes the operation issued by pbr_sequencer, drives pbr_horner.
`timescale 1ns / 1ps

module pbr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbr_pkg::t_ctrl      i_ctrl,
    input  logic                i_in_valid,
    input  pbr_pkg::t_in_item   i_in_item,
    input  logic                i_out_stall,
    input  pbr_pkg::t_eval_rsp  i_eval,
    output pbr_pkg::t_eval_req  o_eval,
    output pbr_pkg::t_cond      o_cond,
    output logic                o_out_valid,
    output pbr_pkg::t_out_item  o_out_item
);

    logic signed [pbr_pkg::XW-1:0]   r_a;
    logic signed [pbr_pkg::XW-1:0]   r_b;
    logic [pbr_pkg::TOL_W-1:0]       r_tol;
    logic signed [pbr_pkg::XW-1:0]   r_fa;
    logic signed [pbr_pkg::XW-1:0]   r_fb;
    logic signed [pbr_pkg::XW-1:0]   r_m;
    logic signed [pbr_pkg::XW-1:0]   r_fm;
    logic signed [pbr_pkg::XW:0]     r_w;
    logic [pbr_pkg::TSH_W-1:0]       r_tsh;
    logic [pbr_pkg::CNT_W-1:0]       r_k;
    logic [pbr_pkg::CNT_W-1:0]       r_steps;
    logic [1:0]                      r_status;
    logic                            r_out_valid;
    pbr_pkg::t_out_item              r_out;

    logic signed [pbr_pkg::XW:0]     ab_sum;
    logic signed [pbr_pkg::XW-1:0]   mid;
    logic [pbr_pkg::XW-1:0]          fm_mag;
    logic                            w_pos;
    logic                            out_free;
    logic                            fm_fa_pos;
    logic                            fm_fb_pos;

    // Both nonzero and of one sign
    function automatic logic same_pos(input logic signed [pbr_pkg::XW-1:0] u,
                                      input logic signed [pbr_pkg::XW-1:0] v);
        return (u != '0) && (v != '0) && (u[pbr_pkg::XW-1] == v[pbr_pkg::XW-1]);
    endfunction

    // Floor midpoint of the interval
    assign ab_sum = {r_a[pbr_pkg::XW-1], r_a} + {r_b[pbr_pkg::XW-1], r_b};
    assign mid    = ab_sum[pbr_pkg::XW:1];

    assign fm_mag    = r_fm[pbr_pkg::XW-1] ? -r_fm : r_fm;
    assign w_pos     = !r_w[pbr_pkg::XW] && (r_w != '0);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign fm_fa_pos = same_pos(r_fm, r_fa);
    assign fm_fb_pos = same_pos(r_fm, r_fb);

    // Flags for the sequencer
    assign o_cond.in_valid   = i_in_valid;
    assign o_cond.eval_busy  = i_eval.busy;
    assign o_cond.same_ab    = same_pos(r_fa, r_fb);
    assign o_cond.kgrow      = w_pos && (r_k < pbr_pkg::CNT_W'(pbr_pkg::MAX_STEPS)) &&
                               ((r_tol == '0) ||
                                ((r_k < pbr_pkg::CNT_W'(pbr_pkg::KSHIFT_LIMIT)) &&
                                 (r_tsh < pbr_pkg::TSH_W'(unsigned'(r_w)))));
    assign o_cond.within_tol = (fm_mag <= pbr_pkg::XW'(r_tol));
    assign o_cond.more_steps = (r_steps <= r_k);
    assign o_cond.out_free   = out_free;

    // Start the Horner unit at a, b or the midpoint
    always_comb begin
        o_eval.start = 1'b0;
        o_eval.x     = r_a;
        unique case (i_ctrl.op)
            pbr_pkg::OP_EVAL_A: begin
                o_eval.start = 1'b1;
                o_eval.x     = r_a;
            end
            pbr_pkg::OP_EVAL_B: begin
                o_eval.start = 1'b1;
                o_eval.x     = r_b;
            end
            pbr_pkg::OP_MID: begin
                o_eval.start = 1'b1;
                o_eval.x     = mid;
            end
            default: begin
                o_eval.start = 1'b0;
                o_eval.x     = r_a;
            end
        endcase
    end

    // Execute the current operation
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            pbr_pkg::OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_a   <= i_in_item.left_end;
                    r_b   <= i_in_item.right_end;
                    r_tol <= i_in_item.tolerance;
                end
            end
            pbr_pkg::OP_STORE_FA: r_fa <= i_eval.result;
            pbr_pkg::OP_STORE_FB: r_fb <= i_eval.result;
            pbr_pkg::OP_KINIT: begin
                r_k     <= '0;
                r_steps <= '0;
                r_tsh   <= pbr_pkg::TSH_W'(r_tol);
                r_w     <= {r_b[pbr_pkg::XW-1], r_b} - {r_a[pbr_pkg::XW-1], r_a};
            end
            pbr_pkg::OP_KSTEP: begin
                if (o_cond.kgrow) begin
                    r_k   <= r_k + pbr_pkg::CNT_W'(1);
                    r_tsh <= r_tsh << 1;
                end
            end
            pbr_pkg::OP_MID: r_m <= mid;
            pbr_pkg::OP_STORE_FM: begin
                r_fm    <= i_eval.result;
                r_steps <= r_steps + pbr_pkg::CNT_W'(1);
            end
            pbr_pkg::OP_UPDATE: begin
                if (fm_fa_pos) begin
                    r_a  <= r_m;
                    r_fa <= r_fm;
                end else if (fm_fb_pos) begin
                    r_b  <= r_m;
                    r_fb <= r_fm;
                end
            end
            pbr_pkg::OP_SET_LIMIT: r_status <= pbr_pkg::ST_LIMIT;
            pbr_pkg::OP_SET_OK:    r_status <= pbr_pkg::ST_OK;
            pbr_pkg::OP_SET_NOSIGN: begin
                r_status <= pbr_pkg::ST_NOSIGN;
                r_m      <= '0;
                r_fm     <= '0;
                r_steps  <= '0;
                r_k      <= '0;
            end
            default: begin
            end
        endcase
    end

    // Result register: load on emit when free, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == pbr_pkg::OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == pbr_pkg::OP_EMIT && out_free) begin
            r_out.root_estimate <= r_m;
            r_out.value_at_root <= r_fm;
            r_out.steps_done    <= r_steps;
            r_out.step_limit    <= r_k;
            r_out.status        <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // Running out of steps means exactly one midpoint past the limit
    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == pbr_pkg::ST_LIMIT) |->
        (r_out.steps_done == r_out.step_limit + pbr_pkg::CNT_W'(1)))
        else $error("step count does not match limit");
    // A failed sign test reports no midpoints
    a_nosign_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == pbr_pkg::ST_NOSIGN) |->
        (r_out.steps_done == '0 && r_out.step_limit == '0))
        else $error("no-sign result carries steps");
`endif

endmodule

// File: hw/rtl/polynomial_bisection_root.sv
// Top level of the polynomial bisection root finder.
// Depends on pbr_pkg, pbr_horner, pbr_sequencer and pbr_datapath.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | into      | i_in_valid / o_in_stall    | i_in_item  (pbr_pkg::t_in_item)
//   out     | out of    | o_out_valid / i_out_stall  | o_out_item (pbr_pkg::t_out_item)
//   cfg     | into      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item at a time: o_in_stall is low only while the sequencer sits at its idle word.
// Per item the sequencer evaluates f(a) and f(b), derives the step limit K (at most 48) from the
// interval width and tolerance, then evaluates at most K + 1 midpoints, with D the degree in use.
// Every evaluation runs its D terms one at a time through the shared multiplier of pbr_horner.
// The result register is held while i_out_stall is high; the sequencer loops over its emit and emit-hold words.
// Reset (synchronous, active low) clears degree and coefficients to zero and returns to idle.
`timescale 1ns / 1ps

module polynomial_bisection_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pbr_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pbr_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [pbr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pbr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    pbr_pkg::t_cfg_wr   cfg;
    pbr_pkg::t_eval_req eval_req;
    pbr_pkg::t_eval_rsp eval_rsp;
    pbr_pkg::t_cond     cond;
    pbr_pkg::t_ctrl     ctrl;

    // Gather the configuration write
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Take a new item only at the idle word
    assign o_in_stall = !ctrl.idle;

    pbr_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    pbr_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (eval_req),
        .o_rsp   (eval_rsp)
    );

    pbr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_eval      (eval_rsp),
        .o_eval      (eval_req),
        .o_cond      (cond),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
